@@ sv/arkf_pkg.sv @@
`timescale 1ns / 1ps

package arkf_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CFG_W    = 31;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned SUM_W    = 36;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE_ANGLE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE_RATE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE   = 8'd3;

    localparam logic [CFG_W-1:0] RST_SAMPLE_INTERVAL     = 31'd655;
    localparam logic [CFG_W-1:0] RST_PROCESS_NOISE_ANGLE = 31'd65536;
    localparam logic [CFG_W-1:0] RST_PROCESS_NOISE_RATE  = 31'd65536;
    localparam logic [CFG_W-1:0] RST_MEASUREMENT_NOISE   = 31'd0;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

    function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return S32_MAX;
        else if (v < -64'sd2147483648)
            return S32_MIN;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat36(input logic signed [SUM_W-1:0] v);
        if (v > 36'sd2147483647)
            return S32_MAX;
        else if (v < -36'sd2147483648)
            return S32_MIN;
        else
            return v[31:0];
    endfunction

endpackage

@@ sv/arkf_if.sv @@
`timescale 1ns / 1ps

interface arkf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [arkf_pkg::DATA_W-1:0]    measured_angle;
    logic signed [arkf_pkg::DATA_W-1:0]    measured_rate;

    modport source (output valid, output measured_angle, output measured_rate, input ready);
    modport sink   (input valid, input measured_angle, input measured_rate, output ready);
endinterface

interface arkf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [arkf_pkg::DATA_W-1:0]    filtered_angle;
    logic signed [arkf_pkg::DATA_W-1:0]    filtered_rate;
    logic                                  zero_denominator;

    modport source (output valid, output filtered_angle, output filtered_rate,
                    output zero_denominator, input ready);
    modport sink   (input valid, input filtered_angle, input filtered_rate,
                    input zero_denominator, output ready);
endinterface

interface arkf_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [arkf_pkg::CFG_IDX_W-1:0]        index;
    logic [arkf_pkg::DATA_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/arkf_mul.sv @@
`timescale 1ns / 1ps

// Bit-serial signed multiplier: one multiplier bit per cycle.
module arkf_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [arkf_pkg::DATA_W-1:0]   a,
    input  logic signed [arkf_pkg::DATA_W-1:0]   b,
    output logic                                 done,
    output logic signed [63:0]                   prod
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] mcand_reg;
    logic [32:0] hi_reg;
    logic [31:0] lo_reg;
    logic        neg_reg;

    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [32:0] sum;
    logic [63:0] mag;

    assign a_mag = a[31] ? (~a + 32'd1) : a;
    assign b_mag = b[31] ? (~b + 32'd1) : b;
    assign sum   = hi_reg + {1'b0, (lo_reg[0] ? mcand_reg : 32'd0)};
    assign mag   = {hi_reg[31:0], lo_reg};
    assign prod  = neg_reg ? -$signed(mag) : $signed(mag);
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            mcand_reg <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            neg_reg   <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            mcand_reg <= a_mag;
            hi_reg    <= '0;
            lo_reg    <= b_mag;
            neg_reg   <= a[31] ^ b[31];
        end
        else if (busy_reg)
        begin
            hi_reg  <= {1'b0, sum[32:1]};
            lo_reg  <= {sum[0], lo_reg[31:1]};
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

@@ sv/arkf_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: q = sat((a << FRAC_BITS) / b),
// truncated toward zero.
module arkf_div
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [arkf_pkg::DATA_W-1:0]   a,
    input  logic signed [arkf_pkg::DATA_W-1:0]   b,
    output logic                                 done,
    output logic signed [arkf_pkg::DATA_W-1:0]   q
);

    localparam int unsigned NW    = 32 + FRAC_BITS;
    localparam int unsigned CNT_W = $clog2(NW);
    localparam logic [NW-1:0] MAG_MAXP = NW'(33'h07FFFFFFF);
    localparam logic [NW-1:0] MAG_MAXN = NW'(33'h080000000);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    num_reg;
    logic [31:0]      den_reg;
    logic [31:0]      rem_reg;
    logic [NW-1:0]    quo_reg;
    logic             neg_reg;

    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign a_mag = a[31] ? (~a + 32'd1) : a;
    assign b_mag = b[31] ? (~b + 32'd1) : b;
    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign done  = done_reg;

    always_comb
    begin
        if (neg_reg)
            q = (quo_reg > MAG_MAXN) ? arkf_pkg::S32_MIN : (~quo_reg[31:0] + 32'd1);
        else
            q = (quo_reg > MAG_MAXP) ? arkf_pkg::S32_MAX : quo_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= {a_mag, FRAC_BITS'(0)};
            den_reg  <= b_mag;
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= a[31] ^ b[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
            num_reg <= {num_reg[NW-2:0], 1'b0};
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

@@ sv/angle_rate_kalman_filter_core.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Transfer        Payload
// in_ch     in   valid & ready   measured_angle, measured_rate
// out_ch    out  valid & ready   filtered_angle, filtered_rate, zero_denominator
// cfg       in   valid & ready   index (0..3), data[30:0]; ready is always high
//
// One item at a time. A sequencer runs 17 multiplies on a bit-serial multiplier
// and 3 divides on a bit-serial divider, then loads the output register. A zero
// sample interval or zero denominator skips that divide and writes a zero result.
// Reset: est = 0, cov = identity, registers at defaults. The output register holds
// a result until taken; the next item may already run.
module angle_rate_kalman_filter_core
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    arkf_in_if.sink       in_ch,
    arkf_out_if.source    out_ch,
    arkf_cfg_if.sink      cfg
);

    localparam logic signed [31:0] QONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_WAIT, S_OUT} state_t;
    typedef enum logic [4:0] {
        ST_ACC, ST_HDT, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
        ST_G0, ST_G1, ST_EA, ST_ER,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic [30:0] dt_reg, qa_reg, qr_reg, rn_reg;

    logic signed [31:0] est_angle_reg, est_rate_reg;
    logic signed [31:0] cov_aa_reg, cov_ar_reg, cov_ra_reg, cov_rr_reg;
    logic signed [31:0] m_angle_reg, m_rate_reg;
    logic signed [31:0] acc_reg, hdt_reg, m1_reg;
    logic signed [31:0] f_angle_reg, f_rate_reg;
    logic signed [31:0] t00_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] g0_reg, g1_reg, tmp_reg;
    logic               zd_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_angle_reg, out_rate_reg;
    logic               out_zd_reg;

    // datapath
    logic signed [31:0] dt_s, diff, den, innov, one_g0, one_g1, num_g0, num_g1;
    logic signed [31:0] opa, opb, mul_q, qv;
    logic signed [63:0] prod;
    logic signed [31:0] div_q;
    logic               mul_done, div_done, mul_start, div_start;
    logic               is_div, skip, wb_en;

    function automatic logic signed [arkf_pkg::SUM_W-1:0] sx(input logic signed [31:0] v);
        return arkf_pkg::SUM_W'(v);
    endfunction

    function automatic logic signed [arkf_pkg::SUM_W-1:0] ux(input logic [30:0] v);
        return $signed({5'd0, v});
    endfunction

    assign dt_s   = $signed({1'b0, dt_reg});
    assign diff   = arkf_pkg::sat36(sx(m_rate_reg) - sx(est_rate_reg));
    assign den    = arkf_pkg::sat36(sx(p00_reg) + sx(p01_reg) + sx(p10_reg)
                                    + sx(p11_reg) + ux(rn_reg));
    assign num_g0 = arkf_pkg::sat36(sx(p00_reg) + sx(p01_reg));
    assign num_g1 = arkf_pkg::sat36(sx(p10_reg) + sx(p11_reg));
    assign innov  = arkf_pkg::sat36(sx(m_angle_reg) + sx(m_rate_reg)
                                    - sx(f_angle_reg) - sx(f_rate_reg));
    assign one_g0 = arkf_pkg::sat36(sx(QONE) - sx(g0_reg));
    assign one_g1 = arkf_pkg::sat36(sx(QONE) - sx(g1_reg));

    assign is_div = (step_reg == ST_ACC) || (step_reg == ST_G0) || (step_reg == ST_G1);
    assign skip   = ((step_reg == ST_ACC) && (dt_reg == '0))
                 || (((step_reg == ST_G0) || (step_reg == ST_G1)) && (den == '0));

    assign mul_start = (state_reg == S_LAUNCH) && !is_div;
    assign div_start = (state_reg == S_LAUNCH) && is_div && !skip;

    always_comb
    begin
        unique case (step_reg)
            ST_ACC:  begin opa = diff;         opb = dt_s;        end
            ST_HDT:  begin opa = dt_s;         opb = dt_s;        end
            ST_M1:   begin opa = dt_s;         opb = est_rate_reg; end
            ST_M2:   begin opa = hdt_reg;      opb = acc_reg;     end
            ST_M3:   begin opa = dt_s;         opb = acc_reg;     end
            ST_M4:   begin opa = dt_s;         opb = cov_ra_reg;  end
            ST_M5:   begin opa = dt_s;         opb = cov_rr_reg;  end
            ST_M6:   begin opa = p01_reg;      opb = dt_s;        end
            ST_G0:   begin opa = num_g0;       opb = den;         end
            ST_G1:   begin opa = num_g1;       opb = den;         end
            ST_EA:   begin opa = g0_reg;       opb = innov;       end
            ST_ER:   begin opa = g1_reg;       opb = innov;       end
            ST_C0:   begin opa = one_g0;       opb = p00_reg;     end
            ST_C1:   begin opa = g0_reg;       opb = p10_reg;     end
            ST_C2:   begin opa = one_g0;       opb = p01_reg;     end
            ST_C3:   begin opa = g0_reg;       opb = p11_reg;     end
            ST_C4:   begin opa = one_g1;       opb = p10_reg;     end
            ST_C5:   begin opa = g1_reg;       opb = p00_reg;     end
            ST_C6:   begin opa = one_g1;       opb = p11_reg;     end
            ST_C7:   begin opa = g1_reg;       opb = p01_reg;     end
            default: begin opa = '0;           opb = '0;          end
        endcase
    end

    arkf_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .prod  (prod)
    );

    arkf_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (opa),
        .b     (opb),
        .done  (div_done),
        .q     (div_q)
    );

    // half dt squared takes one extra bit of shift
    assign mul_q = arkf_pkg::sat64((step_reg == ST_HDT) ? (prod >>> (FRAC_BITS + 1))
                                                        : (prod >>> FRAC_BITS));

    always_comb
    begin
        if (state_reg == S_LAUNCH)
            qv = '0;
        else if (is_div)
            qv = div_q;
        else
            qv = mul_q;
    end

    assign wb_en = ((state_reg == S_LAUNCH) && skip)
                || ((state_reg == S_WAIT) && (is_div ? div_done : mul_done));

    assign in_ch.ready             = (state_reg == S_IDLE);
    assign cfg.ready               = 1'b1;
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.filtered_angle   = out_angle_reg;
    assign out_ch.filtered_rate    = out_rate_reg;
    assign out_ch.zero_denominator = out_zd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_ACC;
            dt_reg        <= arkf_pkg::RST_SAMPLE_INTERVAL;
            qa_reg        <= arkf_pkg::RST_PROCESS_NOISE_ANGLE;
            qr_reg        <= arkf_pkg::RST_PROCESS_NOISE_RATE;
            rn_reg        <= arkf_pkg::RST_MEASUREMENT_NOISE;
            est_angle_reg <= '0;
            est_rate_reg  <= '0;
            cov_aa_reg    <= QONE;
            cov_ar_reg    <= '0;
            cov_ra_reg    <= '0;
            cov_rr_reg    <= QONE;
            m_angle_reg   <= '0;
            m_rate_reg    <= '0;
            acc_reg       <= '0;
            hdt_reg       <= '0;
            m1_reg        <= '0;
            f_angle_reg   <= '0;
            f_rate_reg    <= '0;
            t00_reg       <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
            g0_reg        <= '0;
            g1_reg        <= '0;
            tmp_reg       <= '0;
            zd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_angle_reg <= '0;
            out_rate_reg  <= '0;
            out_zd_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == arkf_pkg::REG_SAMPLE_INTERVAL)
                    dt_reg <= cfg.data[30:0];
                else if (cfg.index == arkf_pkg::REG_PROCESS_NOISE_ANGLE)
                    qa_reg <= cfg.data[30:0];
                else if (cfg.index == arkf_pkg::REG_PROCESS_NOISE_RATE)
                    qr_reg <= cfg.data[30:0];
                else if (cfg.index == arkf_pkg::REG_MEASUREMENT_NOISE)
                    rn_reg <= cfg.data[30:0];
            end

            // in S_OUT the output register is reloaded below instead
            if (out_valid_reg && out_ch.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            if (wb_en)
            begin
                unique case (step_reg)
                    ST_ACC: acc_reg <= qv;
                    ST_HDT: hdt_reg <= qv;
                    ST_M1:  m1_reg  <= qv;
                    ST_M2:  f_angle_reg <= arkf_pkg::sat36(sx(est_angle_reg) + sx(m1_reg)
                                                           + sx(qv));
                    ST_M3:  f_rate_reg <= arkf_pkg::sat36(sx(est_rate_reg) + sx(qv));
                    ST_M4:  t00_reg <= arkf_pkg::sat36(sx(cov_aa_reg) + sx(qv));
                    ST_M5:
                    begin
                        // dt*cov_rr serves both F*P and the F^T product
                        p01_reg <= arkf_pkg::sat36(sx(cov_ar_reg) + sx(qv));
                        p10_reg <= arkf_pkg::sat36(sx(cov_ra_reg) + sx(qv));
                        p11_reg <= arkf_pkg::sat36(sx(cov_rr_reg) + ux(qr_reg));
                    end
                    ST_M6:  p00_reg <= arkf_pkg::sat36(sx(t00_reg) + sx(qv) + ux(qa_reg));
                    ST_G0:
                    begin
                        g0_reg <= qv;
                        zd_reg <= (den == '0);
                    end
                    ST_G1:  g1_reg <= qv;
                    ST_EA:  est_angle_reg <= arkf_pkg::sat36(sx(f_angle_reg) + sx(qv));
                    ST_ER:  est_rate_reg  <= arkf_pkg::sat36(sx(f_rate_reg) + sx(qv));
                    ST_C0, ST_C2, ST_C4, ST_C6: tmp_reg <= qv;
                    ST_C1:  cov_aa_reg <= arkf_pkg::sat36(sx(tmp_reg) - sx(qv));
                    ST_C3:  cov_ar_reg <= arkf_pkg::sat36(sx(tmp_reg) - sx(qv));
                    ST_C5:  cov_ra_reg <= arkf_pkg::sat36(sx(tmp_reg) - sx(qv));
                    ST_C7:  cov_rr_reg <= arkf_pkg::sat36(sx(tmp_reg) - sx(qv));
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        m_angle_reg <= in_ch.measured_angle;
                        m_rate_reg  <= in_ch.measured_rate;
                        step_reg    <= ST_ACC;
                        state_reg   <= S_LAUNCH;
                    end
                end
                S_LAUNCH, S_WAIT:
                begin
                    if (state_reg == S_LAUNCH && !skip)
                        state_reg <= S_WAIT;
                    if (wb_en)
                    begin
                        if (step_reg == ST_C7)
                            state_reg <= S_OUT;
                        else
                        begin
                            step_reg  <= step_t'(step_reg + 5'd1);
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_angle_reg <= est_angle_reg;
                        out_rate_reg  <= est_rate_reg;
                        out_zd_reg    <= zd_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
